[design/alist_pkg.sv]
// Shared types for the array list block: operation and status codes and
// the one-hot controller states. No dependencies.
`default_nettype none

package alist_pkg;

  typedef enum logic [1:0] {
    OP_GET    = 2'd0,
    OP_INSERT = 2'd1,
    OP_ERASE  = 2'd2,
    OP_FIND   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_e;

endpackage

`default_nettype wire

[design/array_list_insert_erase_find_top.sv]
// Positional array list held in one slot memory (one read, one write port).
// Rejected items and inserts at the end skip the shift and scan loops. The
// shift and scan loops move one entry per cycle through the single memory
// read port. Reset clears the count, the controller state, the read-valid
// flag and the output valid; the slot memory is not cleared, since only
// entries below the count are ever read. Uses alist_pkg.
`default_nettype none

module array_list_insert_erase_find_top #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned DATA_WIDTH = 32,
  localparam int unsigned IW = $clog2(CAPACITY),
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire alist_pkg::op_e        operation_i,
  input  wire logic [IW-1:0]         position_i,
  input  wire logic [DATA_WIDTH-1:0] value_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output alist_pkg::status_e         status_o,
  output logic [DATA_WIDTH-1:0]      data_out_o,
  output logic [IW-1:0]              found_index_o,
  output logic [CW-1:0]              count_o
);
  import alist_pkg::*;

  localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

  // Slot memory and its registered read port.
  logic [DATA_WIDTH-1:0] slots_q [CAPACITY];
  logic [DATA_WIDTH-1:0] rdata_q;
  logic                  rd_en, wr_en;
  logic [IW-1:0]         rd_addr, wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic                  rd_vld_q;
  logic [IW-1:0]         rd_idx_q;

  state_e                state_q, state_d;
  op_e                   op_q, op_d;
  logic [IW-1:0]         tgt_q, tgt_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [IW-1:0]         ptr_q, ptr_d;
  logic                  more_q, more_d;

  status_e               res_status_q, res_status_d;
  logic [DATA_WIDTH-1:0] res_data_q, res_data_d;
  logic [IW-1:0]         res_found_q, res_found_d;

  logic                  out_free, move, idle_like, in_fire;
  logic [CW-1:0]         pos_ext, cnt_m1;

  assign out_free   = !out_valid_o || out_ready_i;
  assign move       = (state_q == S_DONE) && out_free;
  assign idle_like  = (state_q == S_IDLE) || move;
  assign in_ready_o = idle_like;
  assign in_fire    = in_valid_i && idle_like;
  assign pos_ext    = CW'(position_i);
  assign cnt_m1     = cnt_q - CW'(1);

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    tgt_d        = tgt_q;
    val_d        = val_q;
    cnt_d        = cnt_q;
    ptr_d        = ptr_q;
    more_d       = more_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    res_found_d  = res_found_q;
    rd_en        = 1'b0;
    rd_addr      = ptr_q;
    wr_en        = 1'b0;
    wr_addr      = tgt_q;
    wr_data      = val_q;

    if (move) begin
      state_d = S_IDLE;
    end

    if (in_fire) begin
      op_d         = operation_i;
      tgt_d        = position_i;
      val_d        = value_i;
      res_data_d   = '0;
      res_found_d  = '0;
      res_status_d = ST_OK;
      more_d       = 1'b0;
      ptr_d        = position_i + IW'(1);
      case (operation_i)
        OP_GET, OP_ERASE: begin
          if (pos_ext >= cnt_q) begin
            res_status_d = ST_BADPOS;
            state_d      = S_DONE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = position_i;
            more_d  = (operation_i == OP_ERASE) && (pos_ext + CW'(1) < cnt_q);
            state_d = S_RUN;
          end
        end
        OP_INSERT: begin
          if (pos_ext > cnt_q) begin
            res_status_d = ST_BADPOS;
            state_d      = S_DONE;
          end else if (cnt_q == CapCount) begin
            res_status_d = ST_FULL;
            state_d      = S_DONE;
          end else if (pos_ext == cnt_q) begin
            // Appending needs no shift: write the value straight away.
            wr_en   = 1'b1;
            wr_addr = position_i;
            wr_data = value_i;
            cnt_d   = cnt_q + CW'(1);
            state_d = S_DONE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = cnt_m1[IW-1:0];
            ptr_d   = cnt_m1[IW-1:0] - IW'(1);
            more_d  = cnt_m1 > pos_ext;
            state_d = S_RUN;
          end
        end
        OP_FIND: begin
          if (pos_ext > cnt_q) begin
            res_status_d = ST_BADPOS;
            state_d      = S_DONE;
          end else if (pos_ext == cnt_q) begin
            res_status_d = ST_NOTFOUND;
            state_d      = S_DONE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = position_i;
            more_d  = pos_ext + CW'(1) < cnt_q;
            state_d = S_RUN;
          end
        end
        default: begin
          state_d = S_DONE;
        end
      endcase
    end

    if (state_q == S_RUN) begin
      // Keep one read in flight; the data of the previous read is handled below.
      rd_en   = more_q;
      rd_addr = ptr_q;
      if (more_q) begin
        if (op_q == OP_INSERT) begin
          ptr_d  = ptr_q - IW'(1);
          more_d = ptr_q != tgt_q;
        end else begin
          ptr_d  = ptr_q + IW'(1);
          more_d = CW'(ptr_q) + CW'(1) < cnt_q;
        end
      end
      case (op_q)
        OP_GET: begin
          res_status_d = ST_OK;
          res_data_d   = rdata_q;
          state_d      = S_DONE;
        end
        OP_INSERT: begin
          wr_en = 1'b1;
          if (rd_vld_q) begin
            wr_addr = rd_idx_q + IW'(1);
            wr_data = rdata_q;
          end else begin
            // Shift has drained: place the new value at its position.
            wr_addr      = tgt_q;
            wr_data      = val_q;
            cnt_d        = cnt_q + CW'(1);
            res_status_d = ST_OK;
            state_d      = S_DONE;
          end
        end
        OP_ERASE: begin
          if (rd_vld_q) begin
            if (rd_idx_q == tgt_q) begin
              res_data_d = rdata_q;
            end else begin
              wr_en   = 1'b1;
              wr_addr = rd_idx_q - IW'(1);
              wr_data = rdata_q;
            end
            if (!more_q) begin
              cnt_d        = cnt_m1;
              res_status_d = ST_OK;
              state_d      = S_DONE;
            end
          end
        end
        OP_FIND: begin
          if (rd_vld_q) begin
            if (rdata_q == val_q) begin
              res_status_d = ST_OK;
              res_found_d  = rd_idx_q;
              state_d      = S_DONE;
            end else if (!more_q) begin
              res_status_d = ST_NOTFOUND;
              state_d      = S_DONE;
            end
          end
        end
        default: begin
          state_d = S_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slots_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q  <= slots_q[rd_addr];
      rd_idx_q <= rd_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      more_q      <= 1'b0;
      rd_vld_q    <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      more_q   <= more_d;
      rd_vld_q <= rd_en;
      if (move) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    tgt_q        <= tgt_d;
    val_q        <= val_d;
    ptr_q        <= ptr_d;
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
    res_found_q  <= res_found_d;
    if (move) begin
      status_o      <= res_status_q;
      data_out_o    <= res_data_q;
      found_index_o <= res_found_q;
      count_o       <= cnt_q;
    end
  end

  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CapCount)
    else $error("count exceeds capacity");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("read and write hit the same slot in one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q != S_IDLE))
    else $error("accepted item did not start");

  a_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN && op_q == OP_INSERT) |-> (cnt_q < CapCount))
    else $error("insert shift running on a full list");

endmodule

`default_nettype wire
